### hw/rtl/ppmsd_pkg.sv
// ----------------------------------------------------------------------------
// ppmsd_pkg
// Shared types, codes and constants of the PPM image stream decoder.
// ----------------------------------------------------------------------------
package ppmsd_pkg;

  localparam int unsigned MAX_DIM_DEF = 16384;
  localparam int unsigned TOKEN_KEEP  = 63;      // token bytes that count
  localparam int unsigned DIV_STEPS   = 24;      // quotient bits per sample
  localparam int unsigned DIV_CNT_W   = 5;
  localparam int unsigned PROD_W      = 24;      // width of v * 255
  localparam int unsigned OUT_DATA_W  = 96;

  localparam logic [7:0]  CHR_P      = 8'h50;
  localparam logic [7:0]  CHR_3      = 8'h33;
  localparam logic [7:0]  CHR_6      = 8'h36;
  localparam logic [7:0]  CHR_0      = 8'h30;
  localparam logic [7:0]  CHR_9      = 8'h39;
  localparam logic [7:0]  CHR_PLUS   = 8'h2B;
  localparam logic [7:0]  CHR_HASH   = 8'h23;
  localparam logic [7:0]  CHR_LF     = 8'h0A;
  localparam logic [7:0]  CHR_SPACE  = 8'h20;
  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [15:0] VALUE_SAT  = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_MAGIC  = 3'd0,
    PH_WIDTH  = 3'd1,
    PH_HEIGHT = 3'd2,
    PH_MAXV   = 3'd3,
    PH_BINARY = 3'd4,
    PH_ASCII  = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MAGIC     = 2'd0,
    ERR_HEADER    = 2'd1,
    ERR_TRUNCATED = 2'd2,
    ERR_TOO_LARGE = 2'd3
  } err_t;

  // datapath commands issued by the controller
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_EOFTOK,
    CMD_EOFERR,
    CMD_DIV_START,
    CMD_DIV_STEP,
    CMD_SAMPLE
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_SAMPLE,
    ST_EOF_TOK,
    ST_EOF_ERR
  } state_t;

  typedef struct packed {
    logic [5:0]  len;
    logic [15:0] value;
    logic        ended;
    logic [7:0]  first;
    logic [7:0]  second;
  } tok_t;

  typedef struct packed {
    kind_t       kind;
    logic [13:0] column;
    logic [13:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last_pixel;
    logic [14:0] image_width;
    logic [14:0] image_height;
    logic [7:0]  max_value;
    err_t        error_code;
    logic        end_of_run;
  } res_t;

  typedef struct packed {
    logic slot_free;    // output register can take a result this cycle
    logic need_sample;  // the current command produced a sample
    logic need_div;     // max value calls for scaling
    logic div_done;     // last quotient step in progress
    logic eof;          // current byte is the file's last
  } dp_sts_t;

endpackage

### hw/rtl/ppmsd_ctrl.sv
// ----------------------------------------------------------------------------
// ppmsd_ctrl
// Sequencer: steps each accepted byte through scan, scaling, sample and
// end-of-file handling, one datapath command per cycle except on output stalls.
// ----------------------------------------------------------------------------
module ppmsd_ctrl import ppmsd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd       = CMD_LOAD;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.slot_free) begin
          cmd = CMD_SCAN;
          if (sts.need_sample) begin
            state_nxt = sts.need_div ? ST_DIV_LOAD : ST_SAMPLE;
          end else if (sts.eof) begin
            state_nxt = ST_EOF_TOK;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DIV_LOAD: begin
        cmd       = CMD_DIV_START;
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd = CMD_DIV_STEP;
        if (sts.div_done) begin
          state_nxt = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        if (sts.slot_free) begin
          cmd       = CMD_SAMPLE;
          state_nxt = sts.eof ? ST_EOF_TOK : ST_IDLE;
        end
      end
      ST_EOF_TOK: begin
        if (sts.slot_free) begin
          cmd = CMD_EOFTOK;
          if (sts.need_sample) begin
            state_nxt = sts.need_div ? ST_DIV_LOAD : ST_SAMPLE;
          end else begin
            state_nxt = ST_EOF_ERR;
          end
        end
      end
      ST_EOF_ERR: begin
        if (sts.slot_free) begin
          cmd       = CMD_EOFERR;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/ppmsd_dp.sv
// ----------------------------------------------------------------------------
// ppmsd_dp
// Parser state, header checks, radix-2 sample scaler, pixel counters and
// the output register.
// ----------------------------------------------------------------------------
module ppmsd_dp import ppmsd_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic [7:0] in_byte,
  input  logic       in_eof,
  input  logic       out_tready,
  output dp_sts_t    sts,
  output logic       out_valid,
  output res_t       out_res
);

  localparam int unsigned CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  // parser state
  phase_t            phase_r, phase_nxt;
  logic              in_comment_r, in_comment_nxt;
  logic              in_token_r, in_token_nxt;
  tok_t              tok_r, tok_nxt;
  logic              ascii_r, ascii_nxt;
  logic [15:0]       width_r, width_nxt;
  logic [15:0]       height_r, height_nxt;
  logic [7:0]        maxv_r, maxv_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [1:0]        chan_r, chan_nxt;
  logic [7:0]        held_red_r, held_red_nxt;
  logic [7:0]        held_green_r, held_green_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [7:0]        byte_r, byte_nxt;
  logic              eof_r, eof_nxt;
  logic [15:0]       sample_v_r, sample_v_nxt;
  logic [PROD_W-1:0] div_num_r, div_num_nxt;
  logic [7:0]        div_rem_r, div_rem_nxt;
  logic [7:0]        div_q_r, div_q_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  res_t              out_res_r, out_res_nxt;

  // token completion
  phase_t      fin_phase;
  logic [15:0] fin_width, fin_height;
  logic [7:0]  fin_maxv;
  logic        fin_ascii, fin_clear, fin_emit, fin_sample;
  res_t        fin_res;

  logic        tokenized, apply_fin, emit, need_sample, need_div, slot_free;
  res_t        res;
  tok_t        tok_fresh;
  logic [7:0]  scaled;
  logic [8:0]  rem_sh;
  logic [16:0] col_inc, row_inc;
  logic        last;

  function automatic tok_t add_char(tok_t t, logic [7:0] c);
    tok_t        r;
    logic [19:0] acc;
    r   = t;
    acc = '0;
    if (t.len < 6'(TOKEN_KEEP)) begin
      r.len = t.len + 6'd1;
      if (t.len == 6'd0) r.first = c;
      if (t.len == 6'd1) r.second = c;
      if (!t.ended) begin
        if (c >= CHR_0 && c <= CHR_9) begin
          acc     = 20'(t.value) * 20'd10 + 20'(c - CHR_0);
          r.value = (acc > 20'(VALUE_SAT)) ? VALUE_SAT : acc[15:0];
        end else if (!(t.len == 6'd0 && c == CHR_PLUS)) begin
          r.ended = 1'b1;
        end
      end
    end
    return r;
  endfunction

  assign slot_free = !out_valid_r || out_tready;
  assign need_div  = (maxv_r != FULL_SCALE) && (maxv_r != 8'd0);
  assign tokenized = (phase_r <= PH_MAXV) || (phase_r == PH_ASCII);
  assign scaled    = need_div ? div_q_r : sample_v_r[7:0];
  assign rem_sh    = {div_rem_r, div_num_r[PROD_W-1]};
  assign col_inc   = 17'(col_r) + 17'd1;
  assign row_inc   = 17'(row_r) + 17'd1;
  assign last      = (col_inc >= {1'b0, width_r}) && (row_inc >= {1'b0, height_r});

  always_comb begin
    tok_fresh       = tok_r;
    tok_fresh.len   = '0;
    tok_fresh.value = '0;
    tok_fresh.ended = 1'b0;
  end

  // what a completed token does in the current phase
  always_comb begin
    fin_phase  = phase_r;
    fin_width  = width_r;
    fin_height = height_r;
    fin_maxv   = maxv_r;
    fin_ascii  = ascii_r;
    fin_clear  = 1'b0;
    fin_emit   = 1'b0;
    fin_sample = 1'b0;
    fin_res    = '0;
    case (phase_r)
      PH_MAGIC: begin
        if (tok_r.len == 6'd2 && tok_r.first == CHR_P &&
            (tok_r.second == CHR_6 || tok_r.second == CHR_3)) begin
          fin_ascii = (tok_r.second == CHR_3);
          fin_phase = PH_WIDTH;
        end else begin
          fin_phase          = PH_DONE;
          fin_emit           = 1'b1;
          fin_res.kind       = KIND_ERROR;
          fin_res.error_code = ERR_MAGIC;
        end
      end
      PH_WIDTH: begin
        fin_width = tok_r.value;
        fin_phase = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        fin_height = tok_r.value;
        fin_phase  = PH_MAXV;
      end
      PH_MAXV: begin
        fin_emit = 1'b1;
        if (width_r == 16'd0 || height_r == 16'd0 || tok_r.value == 16'd0 ||
            tok_r.value > 16'(FULL_SCALE)) begin
          fin_phase          = PH_DONE;
          fin_res.kind       = KIND_ERROR;
          fin_res.error_code = ERR_HEADER;
        end else if (width_r > 16'(MAX_DIM) || height_r > 16'(MAX_DIM)) begin
          fin_phase          = PH_DONE;
          fin_res.kind       = KIND_ERROR;
          fin_res.error_code = ERR_TOO_LARGE;
        end else begin
          fin_maxv             = tok_r.value[7:0];
          fin_clear            = 1'b1;
          fin_phase            = ascii_r ? PH_ASCII : PH_BINARY;
          fin_res.kind         = KIND_HEADER;
          fin_res.image_width  = width_r[14:0];
          fin_res.image_height = height_r[14:0];
          fin_res.max_value    = tok_r.value[7:0];
        end
      end
      PH_ASCII: begin
        fin_sample = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    phase_nxt      = phase_r;
    in_comment_nxt = in_comment_r;
    in_token_nxt   = in_token_r;
    tok_nxt        = tok_r;
    ascii_nxt      = ascii_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    maxv_nxt       = maxv_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    chan_nxt       = chan_r;
    held_red_nxt   = held_red_r;
    held_green_nxt = held_green_r;
    byte_nxt       = byte_r;
    eof_nxt        = eof_r;
    sample_v_nxt   = sample_v_r;
    div_num_nxt    = div_num_r;
    div_rem_nxt    = div_rem_r;
    div_q_nxt      = div_q_r;
    div_cnt_nxt    = div_cnt_r;
    apply_fin      = 1'b0;
    need_sample    = 1'b0;
    emit           = 1'b0;
    res            = '0;

    case (cmd)
      CMD_LOAD: begin
        byte_nxt = in_byte;
        eof_nxt  = in_eof;
      end
      CMD_SCAN: begin
        if (phase_r == PH_BINARY) begin
          need_sample  = 1'b1;
          sample_v_nxt = {8'h00, byte_r};
        end else if (tokenized) begin
          if (in_comment_r) begin
            if (byte_r == CHR_LF) in_comment_nxt = 1'b0;
          end else if (in_token_r) begin
            if (byte_r <= CHR_SPACE) begin
              in_token_nxt = 1'b0;
              apply_fin    = 1'b1;
            end else begin
              tok_nxt = add_char(tok_r, byte_r);
            end
          end else if (byte_r == CHR_HASH) begin
            in_comment_nxt = 1'b1;
          end else if (byte_r > CHR_SPACE) begin
            in_token_nxt = 1'b1;
            tok_nxt      = add_char(tok_fresh, byte_r);
          end
        end
      end
      CMD_EOFTOK: begin
        if (in_token_r && tokenized) begin
          in_token_nxt = 1'b0;
          apply_fin    = 1'b1;
        end
      end
      CMD_EOFERR: begin
        if (phase_r <= PH_ASCII) begin
          emit           = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNCATED;
        end
        // end of file: back to a fresh image
        phase_nxt      = PH_MAGIC;
        in_comment_nxt = 1'b0;
        in_token_nxt   = 1'b0;
        tok_nxt        = '0;
        ascii_nxt      = 1'b0;
        width_nxt      = '0;
        height_nxt     = '0;
        maxv_nxt       = '0;
        col_nxt        = '0;
        row_nxt        = '0;
        chan_nxt       = '0;
        held_red_nxt   = '0;
        held_green_nxt = '0;
      end
      CMD_DIV_START: begin
        // v * 255 as (v << 8) - v
        div_num_nxt = PROD_W'({sample_v_r, 8'h00}) - PROD_W'(sample_v_r);
        div_rem_nxt = '0;
        div_q_nxt   = '0;
        div_cnt_nxt = DIV_CNT_W'(DIV_STEPS);
      end
      CMD_DIV_STEP: begin
        // restoring step; only the low quotient byte is kept
        div_num_nxt = {div_num_r[PROD_W-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
        if (rem_sh >= {1'b0, maxv_r}) begin
          div_rem_nxt = 8'(rem_sh - {1'b0, maxv_r});
          div_q_nxt   = {div_q_r[6:0], 1'b1};
        end else begin
          div_rem_nxt = rem_sh[7:0];
          div_q_nxt   = {div_q_r[6:0], 1'b0};
        end
      end
      CMD_SAMPLE: begin
        case (chan_r)
          2'd0: begin
            held_red_nxt = scaled;
            chan_nxt     = 2'd1;
          end
          2'd1: begin
            held_green_nxt = scaled;
            chan_nxt       = 2'd2;
          end
          default: begin
            chan_nxt       = 2'd0;
            emit           = 1'b1;
            res.kind       = KIND_PIXEL;
            res.column     = 14'(col_r);
            res.row        = 14'(row_r);
            res.red        = held_red_r;
            res.green      = held_green_r;
            res.blue       = scaled;
            res.last_pixel = last;
            if (last) begin
              phase_nxt = PH_DONE;
            end else if (col_inc >= {1'b0, width_r}) begin
              col_nxt = '0;
              row_nxt = CNT_W'(row_inc);
            end else begin
              col_nxt = CNT_W'(col_inc);
            end
          end
        endcase
      end
      default: ;
    endcase

    if (apply_fin) begin
      phase_nxt  = fin_phase;
      width_nxt  = fin_width;
      height_nxt = fin_height;
      maxv_nxt   = fin_maxv;
      ascii_nxt  = fin_ascii;
      if (fin_clear) begin
        col_nxt  = '0;
        row_nxt  = '0;
        chan_nxt = '0;
      end
      if (fin_sample) begin
        need_sample  = 1'b1;
        sample_v_nxt = tok_r.value;
      end
      emit = fin_emit;
      res  = fin_res;
    end

    // a truncation error follows on an end-of-file byte unless the image closed
    if (cmd == CMD_EOFERR) begin
      res.end_of_run = 1'b1;
    end else begin
      res.end_of_run = !(eof_r && (phase_nxt <= PH_ASCII));
    end

    out_res_nxt   = emit ? res : out_res_r;
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_MAGIC;
      in_comment_r <= 1'b0;
      in_token_r   <= 1'b0;
      tok_r        <= '0;
      ascii_r      <= 1'b0;
      width_r      <= '0;
      height_r     <= '0;
      maxv_r       <= '0;
      col_r        <= '0;
      row_r        <= '0;
      chan_r       <= '0;
      held_red_r   <= '0;
      held_green_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      in_token_r   <= in_token_nxt;
      tok_r        <= tok_nxt;
      ascii_r      <= ascii_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      maxv_r       <= maxv_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      chan_r       <= chan_nxt;
      held_red_r   <= held_red_nxt;
      held_green_r <= held_green_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    eof_r      <= eof_nxt;
    sample_v_r <= sample_v_nxt;
    div_num_r  <= div_num_nxt;
    div_rem_r  <= div_rem_nxt;
    div_q_r    <= div_q_nxt;
    div_cnt_r  <= div_cnt_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign sts.slot_free   = slot_free;
  assign sts.need_sample = need_sample;
  assign sts.need_div    = need_div;
  assign sts.div_done    = (div_cnt_r == DIV_CNT_W'(1));
  assign sts.eof         = eof_r;
  assign out_valid       = out_valid_r;
  assign out_res         = out_res_r;

endmodule

### hw/rtl/ppm_image_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// ppm_image_stream_decoder_top
// PPM (P6 binary / P3 ASCII) byte stream decoder with header and pixel output.
// ----------------------------------------------------------------------------
// Feed the file one byte per input request, with in_tlast on the file's last
// byte. The block skips whitespace and '#' comments between header tokens,
// checks the magic, reads width, height and max value, and then reports one
// header request followed by one pixel request per three samples, each pixel
// tagged with its column and row. Samples are rescaled to v*255/maxval (low 8
// bits) unless maxval is 255. Errors (bad magic, bad header value, too large,
// truncated data) come out as their own request; after an error or the last
// pixel, bytes are ignored until end of file, which rearms for a new image.
// One byte is worked on at a time. A header or comment byte is loaded and
// scanned; a sample byte is loaded, scanned and stored, with a divider load
// and 24 radix-2 steps, one quotient bit per cycle, in between unless maxval
// is 255. An end-of-file byte adds a token-close and an error step, with the
// divide and sample steps between them when it closes an ASCII sample. New
// bytes are taken while the last result still sits in the output register;
// every scan, sample and end-of-file step waits while that register holds a
// result not yet taken, whether or not it writes one; divide steps never wait.
// ----------------------------------------------------------------------------
module ppm_image_stream_decoder_top import ppmsd_pkg::*; #(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF   // largest accepted width/height
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tlast,   // end_of_file
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [13:0] column, [27:14] row, [35:28] red, [43:36] green, [51:44] blue,
  // [52] last_pixel, [67:53] image_width, [82:68] image_height,
  // [90:83] max_value, [92:91] error_code, [95:93] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]            out_tuser,  // [1:0] kind
  output logic                  out_tlast   // end_of_run
);

  cmd_t    cmd;
  dp_sts_t sts;
  res_t    res;

  // sequencer: one command per cycle except on output stalls
  ppmsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // parser, scaler, counters and output register
  ppmsd_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_byte    (in_tdata),
    .in_eof     (in_tlast),
    .out_tready (out_tready),
    .sts        (sts),
    .out_valid  (out_tvalid),
    .out_res    (res)
  );

  // result packing, highest field first, column in the lowest bits
  assign out_tdata = {3'b000, res.error_code, res.max_value, res.image_height,
                      res.image_width, res.last_pixel, res.blue, res.green,
                      res.red, res.row, res.column};
  assign out_tuser = res.kind;
  assign out_tlast = res.end_of_run;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the PPM stream decoder: feeds whole P6/P3 files
// byte by byte and checks every header, pixel and error request it returns.
// ----------------------------------------------------------------------------
// A scoreboard object follows the byte stream with its own decoder state.
// For each byte taken it works out the requests the block must return and
// queues them. Each returned request is checked field by field against the
// oldest queued one. The stimulus opens with a few short hand-made files and
// then sends random files: mostly well-formed headers and data with random
// content, plus bad magics, bad header values, oversized images, truncated
// and padded files, long tokens, comments, signs and plain noise. Both sides
// pause in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module testbench;
  import ppmsd_pkg::*;

  localparam int unsigned CLK_HALF       = 6;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned TARGET_BYTES   = 1350;
  localparam int unsigned CALM_BYTES     = 200;   // last stretch runs without pauses
  localparam int unsigned DRAIN_EVERY    = 8;     // files between full drains
  // slowest byte: a scaled sample divide plus an end-of-file divide, two result
  // stalls and a sender gap, all at their longest; taken many times over
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 80;

  // --------------------------------------------------------------------------
  // Scoreboard: byte-level decoder state and the queue of expected requests
  // --------------------------------------------------------------------------
  class ppm_decode_scoreboard;
    phase_t      phase;
    bit          in_comment, in_token, digits_ended, ascii;
    int unsigned tok_value, tok_len;
    int unsigned width_seen, height_seen, maxv_seen;
    int unsigned col, row, channel;
    logic [7:0]  magic_first, magic_second, red_held, green_held;
    res_t        due_results[$];   // oldest first
    res_t        fresh[$];         // requests caused by the current byte
    int unsigned fail_count;
    int unsigned result_count;

    function new();
      clear();
      fail_count   = 0;
      result_count = 0;
    endfunction

    function void clear();
      phase        = PH_MAGIC;
      in_comment   = 0;
      in_token     = 0;
      digits_ended = 0;
      ascii        = 0;
      tok_value    = 0;
      tok_len      = 0;
      width_seen   = 0;
      height_seen  = 0;
      maxv_seen    = 0;
      col          = 0;
      row          = 0;
      channel      = 0;
      magic_first  = '0;
      magic_second = '0;
      red_held     = '0;
      green_held   = '0;
    endfunction

    function void emit_error(err_t code);
      res_t r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      phase        = PH_DONE;
      fresh.push_back(r);
    endfunction

    // one sample; every third one closes a pixel
    function void take_sample(int unsigned v);
      res_t       r;
      logic [7:0] s;
      if (maxv_seen != FULL_SCALE && maxv_seen != 0) v = (v * 255) / maxv_seen;
      s = 8'(v);
      if (channel == 0) begin
        red_held = s;
        channel  = 1;
        return;
      end
      if (channel == 1) begin
        green_held = s;
        channel    = 2;
        return;
      end
      channel      = 0;
      r            = '0;
      r.kind       = KIND_PIXEL;
      r.column     = 14'(col);
      r.row        = 14'(row);
      r.red        = red_held;
      r.green      = green_held;
      r.blue       = s;
      r.last_pixel = (col + 1 >= width_seen) && (row + 1 >= height_seen);
      fresh.push_back(r);
      if (r.last_pixel) begin
        phase = PH_DONE;
      end else begin
        col++;
        if (col >= width_seen) begin
          col = 0;
          row++;
        end
      end
    endfunction

    function void finish_token();
      res_t r;
      in_token = 0;
      case (phase)
        PH_MAGIC: begin
          if (tok_len == 2 && magic_first == CHR_P &&
              (magic_second == CHR_6 || magic_second == CHR_3)) begin
            ascii = (magic_second == CHR_3);
            phase = PH_WIDTH;
          end else begin
            emit_error(ERR_MAGIC);
          end
        end
        PH_WIDTH: begin
          width_seen = tok_value;
          phase      = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          height_seen = tok_value;
          phase       = PH_MAXV;
        end
        PH_MAXV: begin
          if (width_seen == 0 || height_seen == 0 || tok_value == 0 ||
              tok_value > FULL_SCALE) begin
            emit_error(ERR_HEADER);
          end else if (width_seen > MAX_DIM_DEF || height_seen > MAX_DIM_DEF) begin
            emit_error(ERR_TOO_LARGE);
          end else begin
            maxv_seen      = tok_value;
            col            = 0;
            row            = 0;
            channel        = 0;
            phase          = ascii ? PH_ASCII : PH_BINARY;
            r              = '0;
            r.kind         = KIND_HEADER;
            r.image_width  = 15'(width_seen);
            r.image_height = 15'(height_seen);
            r.max_value    = 8'(tok_value);
            fresh.push_back(r);
          end
        end
        PH_ASCII: take_sample(tok_value);
        default: ;
      endcase
    endfunction

    // only the first TOKEN_KEEP bytes of a token count
    function void add_char(logic [7:0] c);
      int unsigned pos;
      pos = tok_len;
      if (pos >= TOKEN_KEEP) return;
      tok_len = pos + 1;
      if (pos == 0) magic_first = c;
      if (pos == 1) magic_second = c;
      if (digits_ended) return;
      if (c >= CHR_0 && c <= CHR_9) begin
        tok_value = tok_value * 10 + (c - CHR_0);
        if (tok_value > VALUE_SAT) tok_value = VALUE_SAT;
      end else if (!(pos == 0 && c == CHR_PLUS)) begin
        digits_ended = 1;
      end
    endfunction

    // byte request taken: queue whatever it causes
    function void decode_byte(logic [7:0] c, logic eof);
      bit   tokenized;
      res_t tail;
      fresh.delete();
      tokenized = (phase <= PH_MAXV) || (phase == PH_ASCII);
      if (phase == PH_BINARY) begin
        take_sample(c);
      end else if (tokenized) begin
        if (in_comment) begin
          if (c == CHR_LF) in_comment = 0;
        end else if (in_token) begin
          if (c <= CHR_SPACE) finish_token();
          else add_char(c);
        end else if (c == CHR_HASH) begin
          in_comment = 1;
        end else if (c > CHR_SPACE) begin
          in_token     = 1;
          tok_len      = 0;
          tok_value    = 0;
          digits_ended = 0;
          add_char(c);
        end
      end
      if (eof) begin
        // a token closed by end of file is handled before the truncation check
        tokenized = (phase <= PH_MAXV) || (phase == PH_ASCII);
        if (in_token && tokenized) finish_token();
        if (phase <= PH_ASCII) emit_error(ERR_TRUNCATED);
        clear();
      end
      if (fresh.size() != 0) begin
        tail            = fresh.pop_back();
        tail.end_of_run = 1'b1;
        fresh.push_back(tail);
      end
      foreach (fresh[i]) due_results.push_back(fresh[i]);
    endfunction

    task report_mismatch(string what);
      fail_count++;
      if (fail_count <= 40) $display("[%0t] MISMATCH %s", $time, what);
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                  result_count, name, got, want));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data, logic [1:0] user, logic last);
      res_t want;
      result_count++;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("result %0d (kind %0d) with nothing expected",
                                  result_count, user));
        return;
      end
      want = due_results.pop_front();
      compare("kind",         user,          want.kind);
      compare("column",       data[13:0],    want.column);
      compare("row",          data[27:14],   want.row);
      compare("red",          data[35:28],   want.red);
      compare("green",        data[43:36],   want.green);
      compare("blue",         data[51:44],   want.blue);
      compare("last_pixel",   data[52],      want.last_pixel);
      compare("image_width",  data[67:53],   want.image_width);
      compare("image_height", data[82:68],   want.image_height);
      compare("max_value",    data[90:83],   want.max_value);
      compare("error_code",   data[92:91],   want.error_code);
      compare("pad",          data[95:93],   0);
      compare("end_of_run",   last,          want.end_of_run);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block connections
  // --------------------------------------------------------------------------
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  ppm_decode_scoreboard sb;
  logic [7:0]           file_q[$];        // bytes of the file being sent
  int unsigned          bytes_sent  = 0;
  int unsigned          tx_odds     = 0;  // percent chance of a sender pause
  int unsigned          rx_odds     = 0;  // percent chance of a receiver stall
  bit                   calm        = 1'b0;
  int unsigned          rx_hold     = 0;
  int unsigned          quiet_cycles = 0;

  always #(CLK_HALF) clk = ~clk;

  ppm_image_stream_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // --------------------------------------------------------------------------
  // Monitor: both channels are sampled with the values held at the edge.
  // Results are checked before the new byte is predicted, though a byte can
  // never have its own requests out on the same edge anyway.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
      if (in_tvalid && in_tready) sb.decode_byte(in_tdata, in_tlast);
    end
  end

  // Watchdog: too long without any request moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: tready drops in bursts of random length
  always @(posedge clk) begin
    if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else if (rx_hold == 0 && !calm && $urandom_range(1, 100) <= rx_odds) begin
      rx_hold    <= $urandom_range(1, 19);
      out_tready <= 1'b0;
    end else begin
      rx_hold    <= 0;
      out_tready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // One byte request; returns on the edge that takes it. tvalid stays high
  // into the next call unless a pause is drawn.
  task automatic send_byte(logic [7:0] b, logic eof);
    if (!calm && $urandom_range(1, 100) <= tx_odds) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
  endtask

  // hold the sender until every queued request has come back, after letting
  // the monitor queue the requests of the last byte taken
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // File builders
  // --------------------------------------------------------------------------
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) file_q.push_back(s[i]);
  endfunction

  // whitespace run, sometimes followed by a comment up to a line feed
  function automatic void add_space();
    logic [7:0] b;
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h09;
        1:       b = CHR_LF;
        2:       b = 8'h0D;
        3:       b = 8'($urandom_range(0, 32));
        default: b = CHR_SPACE;
      endcase
      file_q.push_back(b);
    end
    if ($urandom_range(0, 9) == 0) begin
      file_q.push_back(CHR_HASH);
      repeat ($urandom_range(0, 6)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CHR_LF) b = CHR_P;
        file_q.push_back(b);
      end
      file_q.push_back(CHR_LF);
    end
  endfunction

  // decimal text with the odd sign, zero run, trailing junk or overlong pad
  function automatic string num_text(int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    case ($urandom_range(0, 39))
      0: s = {"+", s};
      1: s = {"00", s};
      2: s = {s, "z"};
      3: s = {"-", s};
      4: repeat ($urandom_range(55, 66)) s = {"0", s};
      default: ;
    endcase
    return s;
  endfunction

  function automatic string bad_magic();
    case ($urandom_range(0, 6))
      0:       return "P5";
      1:       return "P";
      2:       return "P66";
      3:       return "p6";
      4:       return "P3x";
      5:       return "Q3";
      default: return $sformatf("P%c", 8'($urandom_range(33, 126)));
    endcase
  endfunction

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 29))
      0:       return 0;
      1:       return MAX_DIM_DEF;
      2:       return $urandom_range(MAX_DIM_DEF + 1, 99999);
      3, 4:    return $urandom_range(4, 6);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  function automatic int unsigned pick_maxv();
    case ($urandom_range(0, 19))
      0:                      return 0;
      1:                      return $urandom_range(256, 70000);
      2:                      return 1;
      3, 4, 5, 6, 7, 8, 9:    return 255;
      default:                return $urandom_range(2, 254);
    endcase
  endfunction

  // Random file: mostly a valid header and data with random samples; some
  // files are noise, carry a bad magic, are cut short or padded at the end.
  function automatic void build_file();
    int unsigned pick, w, h, mv, npix, nsamp, v, cut;
    bit          ascii;
    file_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 12)) file_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ascii = $urandom_range(0, 1);
    if ($urandom_range(0, 4) == 0) add_space();
    if (pick < 15) add_text(bad_magic());
    else add_text(ascii ? "P3" : "P6");
    add_space();
    w  = pick_dim();
    h  = pick_dim();
    mv = pick_maxv();
    add_text(num_text(w));
    add_space();
    add_text(num_text(h));
    add_space();
    add_text(num_text(mv));
    npix  = (w >= 1 && w <= 6 && h >= 1 && h <= 6) ? w * h : $urandom_range(1, 4);
    nsamp = 3 * npix;
    if ($urandom_range(0, 7) == 0) nsamp = $urandom_range(0, nsamp - 1);
    if (ascii) begin
      add_space();
      for (int k = 0; k < nsamp; k++) begin
        if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 99999);
        else v = $urandom_range(0, mv);
        add_text(num_text(v));
        // the last sample ends either on whitespace or on end of file
        if (k + 1 < nsamp || $urandom_range(0, 1)) add_space();
      end
    end else begin
      // exactly one delimiter byte, then raw samples
      file_q.push_back(8'($urandom_range(0, 32)));
      repeat (nsamp) file_q.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 15) == 0 && file_q.size() > 1) begin
      cut = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned files;
    int unsigned odds_set[3];
    files    = 0;
    odds_set = '{0, 5, 20};
    sb       = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // P6 1x1 with maxval 2: samples at, below and far above maxval
    file_q.delete();
    add_text("P6\n1 1 2\n");
    file_q.push_back(8'hFF);
    file_q.push_back(8'h00);
    file_q.push_back(8'h02);
    send_file();
    // P3 2x1 behind a comment; end of file closes the first pixel's last
    // sample, so that byte returns a pixel and then a truncation error
    file_q.delete();
    add_text("P3 #\n2 1 9 9 1 2");
    send_file();
    // bad magic closed by end of file
    file_q.delete();
    add_text("Q6");
    send_file();
    wait_drained();

    while (bytes_sent < TARGET_BYTES) begin
      calm    = (bytes_sent + CALM_BYTES >= TARGET_BYTES);
      tx_odds = odds_set[$urandom_range(0, 2)];
      rx_odds = odds_set[$urandom_range(0, 2)];
      build_file();
      send_file();
      files++;
      if (files % DRAIN_EVERY == 0) wait_drained();
    end

    // let the last byte's requests and any late extra ones come out
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
